@@ hdl/floored_log10_stream_assert.svh @@
// ----------------------------------------------------------------------------
// floored_log10_stream assertion macros
// Shared property shorthands for the stream checker.
// ----------------------------------------------------------------------------
`ifndef FLOORED_LOG10_STREAM_ASSERT_SVH
`define FLOORED_LOG10_STREAM_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define FLS_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("fls check failed");

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define FLS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("fls check failed");

`endif

@@ hdl/fls_pkg.sv @@
// ----------------------------------------------------------------------------
// fls_pkg
// Status codes, fixed widths and the log2 table generator for the log10 stream.
// ----------------------------------------------------------------------------
package fls_pkg;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_FLOORED = 2'd1;
	localparam logic [1:0] ST_NONPOS  = 2'd2;
	localparam logic [1:0] ST_INVALID = 2'd3;

	localparam int LOG_FB = 28;   // fraction bits of the log2 table
	localparam int LOG_W  = 29;   // table entries reach 2^28
	localparam int E_W    = 9;    // exponent after denormal normalization
	localparam int V_W    = 37;   // signed log2 in Q28
	localparam int MAG_W  = 36;   // |log2| in Q28
	localparam int MAG_H  = 18;   // split point of the scaling multiply
	localparam int ACC_W  = 65;   // |log2| * log10(2)

	localparam logic [LOG_W-1:0] LOG10_2_Q30 = 29'd323228497;

	// log2(1 + i/2^t) in Q28 by repeated squaring, evaluated at elaboration
	function automatic logic [LOG_W-1:0] log2_entry(input int t, input int i);
		longint unsigned y;
		logic [LOG_W-1:0] r;
		y = (64'd1 << 31) + (64'(i) << (31 - t));
		r = '0;
		if (y >= (64'd1 << 32)) begin
			r = LOG_W'(1) << LOG_FB;
		end else begin
			for (int k = LOG_FB - 1; k >= 0; k--) begin
				y = (y * y) >> 31;
				if (y >= (64'd1 << 32)) begin
					y = y >> 1;
					r[k] = 1'b1;
				end
			end
		end
		return r;
	endfunction

endpackage

@@ hdl/floored_log10_stream.sv @@
// ----------------------------------------------------------------------------
// floored_log10_stream
// Base-10 logarithm of IEEE single samples as signed fixed point, with an
// optional floor for non-positive samples and drop-to-last on error.
// ----------------------------------------------------------------------------
//
// Channel  Dir  Handshake            Payload
// s_*      in   s_tvalid / s_tready  s_tdata = sample_bits, s_tlast = last_sample
// m_*      out  m_tvalid / m_tready  m_tdata = log_value, m_tuser = status,
//                                    m_tlast = last_result
// cfg_*    in   cfg_we               cfg_index selects register, cfg_data value
//
// A positive finite sample passes, between transfer and result, through one
// normalize step per leading zero of a denormal mantissa (up to 23), two
// table reads and three passes through the one shared multiplier.
// NaN, infinity, error and invalid-floor items go from the transfer straight to the final state.
// Dropped items (after an error, up to the item marked last) are taken while idle and leave no result.
// The result sits in an output register; a stalled m_tready holds the
// sequencer in its final state until the register frees up.
// Reset clears control and loads the register defaults; there is no clear pass.
// ----------------------------------------------------------------------------
module floored_log10_stream #(
	parameter int FRACTION_BITS    = 24,
	parameter int TABLE_INDEX_BITS = 6
) (
	input  logic               clk,
	input  logic               arst_n,
	// configuration
	input  logic               cfg_we,
	input  logic               cfg_index,
	input  logic [31:0]        cfg_data,
	// input stream
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [31:0]        s_tdata,   // [31:0] sample_bits
	input  logic               s_tlast,
	// output stream
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic signed [31:0] m_tdata,   // [31:0] log_value
	output logic [1:0]         m_tuser,   // [1:0] status
	output logic               m_tlast
);
	import fls_pkg::*;

	localparam int RB    = 23 - TABLE_INDEX_BITS;          // interpolation bits
	localparam int TBL_N = (1 << TABLE_INDEX_BITS) + 1;    // table entries
	localparam int AW    = TABLE_INDEX_BITS + 1;           // table address width
	localparam int SH    = 58 - FRACTION_BITS;             // final scaling shift
	localparam int MB    = (RB > MAG_H) ? RB : MAG_H;      // multiplier B width

	localparam logic REG_USE_FLOOR  = 1'b0;
	localparam logic REG_FLOOR_BITS = 1'b1;

	typedef enum logic [9:0] {
		S_IDLE = 10'b0000000001,
		S_NORM = 10'b0000000010,
		S_RDA  = 10'b0000000100,
		S_RDB  = 10'b0000001000,
		S_INTP = 10'b0000010000,
		S_ABS  = 10'b0000100000,
		S_MLO  = 10'b0001000000,
		S_MHI  = 10'b0010000000,
		S_RND  = 10'b0100000000,
		S_DONE = 10'b1000000000
	} state_t;

	typedef struct packed {
		logic is_nan;
		logic nonpos;
		logic is_inf;
	} fclass_t;

	function automatic fclass_t classify(input logic [31:0] b);
		fclass_t c;
		c.is_nan = (&b[30:23]) && (|b[22:0]);
		c.nonpos = !c.is_nan && (b[31] || !(|b[30:0]));
		c.is_inf = !c.is_nan && !b[31] && (&b[30:23]);
		return c;
	endfunction

	// Control state
	state_t      state_q;
	logic        halted_q;
	logic        use_floor_q;
	logic [31:0] floor_bits_q;
	logic        m_tvalid_q;

	// Datapath registers
	logic [23:0]             m_q;      // mantissa with hidden bit
	logic signed [E_W-1:0]   e_q;      // unbiased exponent
	logic [LOG_W-1:0]        rom_q;    // registered table read
	logic [LOG_W-1:0]        a_q;      // lower table entry
	logic signed [V_W-1:0]   v_q;      // log2 in Q28
	logic [MAG_W-1:0]        mag_q;
	logic                    neg_q;
	logic [ACC_W-1:0]        acc_q;
	logic [31:0]             val_q;
	logic [1:0]              st_q;
	logic                    lr_q;
	logic [31:0]             m_tdata_q;
	logic [1:0]              m_tuser_q;
	logic                    m_tlast_q;

	// Log2 table, built at elaboration
	logic [LOG_W-1:0] rom_w [TBL_N];
	for (genvar g = 0; g < TBL_N; g++) begin : g_rom
		localparam logic [LOG_W-1:0] ENTRY = log2_entry(TABLE_INDEX_BITS, g);
		assign rom_w[g] = ENTRY;
	end

	// Input decode
	fclass_t     s_cls_w;
	fclass_t     f_cls_w;
	fclass_t     op_cls_w;
	logic        take_w;
	logic        start_w;
	logic        drop_w;
	logic        calc_w;
	logic        err_w;
	logic [31:0] op_w;
	logic [31:0] imm_val_w;
	logic [1:0]  imm_st_w;
	logic        imm_lr_w;
	logic        out_load_w;

	assign s_cls_w  = classify(s_tdata);
	assign f_cls_w  = classify(floor_bits_q);
	assign s_tready = (state_q == S_IDLE);
	assign take_w   = s_tvalid && s_tready;
	assign drop_w   = take_w && halted_q;
	assign start_w  = take_w && !halted_q;
	assign err_w    = s_cls_w.nonpos && !use_floor_q;
	assign op_w     = (s_cls_w.nonpos && use_floor_q) ? floor_bits_q : s_tdata;
	assign op_cls_w = classify(op_w);

	// Settle every case that needs no arithmetic right at the transfer
	always_comb begin
		calc_w    = 1'b0;
		imm_val_w = 32'h0000_0000;
		imm_lr_w  = s_tlast;
		imm_st_w  = s_cls_w.nonpos ? ST_FLOORED : ST_OK;
		if (s_cls_w.is_nan) begin
			imm_st_w = ST_INVALID;
		end else if (err_w) begin
			imm_st_w = ST_NONPOS;
			imm_lr_w = 1'b1;
		end else if (s_cls_w.nonpos && (f_cls_w.is_nan || f_cls_w.nonpos)) begin
			imm_st_w = ST_INVALID;
		end else if (op_cls_w.is_inf) begin
			imm_val_w = 32'h7FFF_FFFF;   // saturate
		end else begin
			calc_w = 1'b1;
		end
	end

	assign out_load_w = (state_q == S_DONE) && (!m_tvalid_q || m_tready);

	// Shared multiplier: interpolation, then both halves of the log10 scaling
	logic [LOG_W-1:0]    diff_w;
	logic [LOG_W-1:0]    mul_a;
	logic [MB-1:0]       mul_b;
	logic [LOG_W+MB-1:0] mul_p;
	logic [LOG_W-1:0]    l_w;
	logic [AW-1:0]       addr_w;

	assign diff_w = (rom_q > a_q) ? (rom_q - a_q) : '0;

	always_comb begin
		mul_a = LOG10_2_Q30;
		mul_b = MB'(mag_q[MAG_H-1:0]);
		case (state_q)
			S_INTP: begin
				mul_a = diff_w;
				mul_b = MB'(m_q[RB-1:0]);
			end
			S_MHI: mul_b = MB'(mag_q[MAG_W-1:MAG_H]);
			default: ;
		endcase
	end

	assign mul_p  = mul_a * mul_b;
	assign l_w    = a_q + LOG_W'(mul_p >> RB);
	assign addr_w = (state_q == S_RDB) ? (AW'(m_q[22:RB]) + AW'(1)) : AW'(m_q[22:RB]);

	// Round half away from zero, then saturate to the 32-bit range
	logic [ACC_W:0] rnd_w;
	logic [31:0]    sat_w;

	assign rnd_w = (ACC_W+1)'(acc_q >> SH) + (ACC_W+1)'(acc_q[SH-1]);

	always_comb begin
		if (neg_q) begin
			if (rnd_w > (ACC_W+1)'(64'h8000_0000)) begin
				sat_w = 32'h8000_0000;
			end else begin
				sat_w = 32'h0000_0000 - rnd_w[31:0];
			end
		end else begin
			if (rnd_w > (ACC_W+1)'(64'h7FFF_FFFF)) begin
				sat_w = 32'h7FFF_FFFF;
			end else begin
				sat_w = rnd_w[31:0];
			end
		end
	end

	// Control: sequencer, drop state, registers, output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			halted_q     <= 1'b0;
			use_floor_q  <= 1'b0;
			floor_bits_q <= 32'h3F80_0000;
			m_tvalid_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_USE_FLOOR:  use_floor_q  <= cfg_data[0];
					REG_FLOOR_BITS: floor_bits_q <= cfg_data;
				endcase
			end

			// error without floor drops the rest of the array; last ends the drop
			if (drop_w && s_tlast) begin
				halted_q <= 1'b0;
			end else if (start_w && !s_cls_w.is_nan && err_w && !s_tlast) begin
				halted_q <= 1'b1;
			end

			if (out_load_w) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: if (start_w) begin
					state_q <= calc_w ? S_NORM : S_DONE;
				end
				S_NORM: if (m_q[23]) begin
					state_q <= S_RDA;
				end
				S_RDA:  state_q <= S_RDB;
				S_RDB:  state_q <= S_INTP;
				S_INTP: state_q <= S_ABS;
				S_ABS:  state_q <= S_MLO;
				S_MLO:  state_q <= S_MHI;
				S_MHI:  state_q <= S_RND;
				S_RND:  state_q <= S_DONE;
				S_DONE: if (out_load_w) begin
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Datapath
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: if (start_w) begin
				val_q <= imm_val_w;
				st_q  <= imm_st_w;
				lr_q  <= imm_lr_w;
				if (op_w[30:23] == 8'h00) begin
					m_q <= {1'b0, op_w[22:0]};
					e_q <= E_W'(-126);
				end else begin
					m_q <= {1'b1, op_w[22:0]};
					e_q <= $signed(E_W'(op_w[30:23])) - E_W'(127);
				end
			end
			S_NORM: if (!m_q[23]) begin
				// one leading zero per cycle
				m_q <= {m_q[22:0], 1'b0};
				e_q <= e_q - E_W'(1);
			end
			S_RDA: rom_q <= rom_w[addr_w];
			S_RDB: begin
				a_q   <= rom_q;
				rom_q <= rom_w[addr_w];
			end
			S_INTP: v_q <= (V_W'(e_q) <<< LOG_FB) + $signed(V_W'(l_w));
			S_ABS: begin
				neg_q <= v_q[V_W-1];
				mag_q <= v_q[V_W-1] ? MAG_W'(-v_q) : MAG_W'(v_q);
			end
			S_MLO: acc_q <= ACC_W'(mul_p);
			S_MHI: acc_q <= acc_q + (ACC_W'(mul_p) << MAG_H);
			S_RND: val_q <= sat_w;
			default: ;
		endcase

		if (out_load_w) begin
			m_tdata_q <= val_q;
			m_tuser_q <= st_q;
			m_tlast_q <= lr_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = $signed(m_tdata_q);
	assign m_tuser  = m_tuser_q;
	assign m_tlast  = m_tlast_q;

endmodule

@@ hdl/fls_checker.sv @@
// ----------------------------------------------------------------------------
// fls_checker
// Port-level checks on the log10 stream, bound to the top level.
// ----------------------------------------------------------------------------
`include "floored_log10_stream_assert.svh"

module fls_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               s_tready,
	input logic               m_tvalid,
	input logic               m_tready,
	input logic signed [31:0] m_tdata,
	input logic [1:0]         m_tuser,
	input logic               m_tlast
);
	import fls_pkg::*;

	// hold a stalled result
	`FLS_ASSERT_NEXT(a_stall_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
	// an error result carries zero and closes the array
	`FLS_ASSERT_NOW(a_err_zero, m_tvalid && m_tuser == ST_NONPOS, m_tlast && m_tdata == 0)
	// an invalid result carries zero
	`FLS_ASSERT_NOW(a_inv_zero, m_tvalid && m_tuser == ST_INVALID, m_tdata == 0)
	// a result only appears while the input side is busy
	`FLS_ASSERT_NOW(a_busy_load, $rose(m_tvalid), !$past(s_tready))

endmodule

bind floored_log10_stream fls_checker u_fls_checker (.*);

@@ test/testbench.sv @@
// ----------------------------------------------------------------------------
// floored_log10_stream testbench
// Streams IEEE single samples through the block and checks every log10 result
// against a scoreboard that predicts value, status and end-of-array flag.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
	import fls_pkg::*;

	localparam int FRAC_BITS   = 24;
	localparam int TBL_BITS    = 6;
	localparam int REST_BITS   = 23 - TBL_BITS;
	localparam int SCALE_SHIFT = 58 - FRAC_BITS;
	localparam longint unsigned LOG10_OF_2_Q30 = 64'd323228497;

	// register indexes of the configuration port
	localparam logic REG_USE_FLOOR  = 1'b0;
	localparam logic REG_FLOOR_BITS = 1'b1;

	// idle cycles that let a dropped item or a slow denormal finish
	localparam int SETTLE_CYCLES = 48;
	localparam int PHASES        = 12;
	localparam int RESULTS_PER_PHASE = 160;

	typedef struct packed {
		logic [31:0] value;
		logic [1:0]  status;
		logic        last;
	} log_result_t;

	// ------------------------------------------------------------------------
	// Scoreboard: predicts each result of an accepted sample and checks the
	// results that leave the block in order.
	// ------------------------------------------------------------------------
	class log10_scoreboard;
		log_result_t expected_q[$];
		logic [28:0] log2_tbl [0:(1 << TBL_BITS)];
		bit          halted;
		bit          use_floor;
		logic [31:0] floor_bits;
		int          errors;

		function new();
			halted     = 1'b0;
			use_floor  = 1'b0;
			floor_bits = 32'h3F80_0000;
			errors     = 0;
			for (int i = 0; i <= (1 << TBL_BITS); i++)
				log2_tbl[i] = log2_point(i);
		endfunction

		// log2(1 + i/2^T) in Q28, one squaring per result bit
		function logic [28:0] log2_point(int i);
			longint unsigned y;
			logic [28:0] acc;
			y = (64'd1 << 31) + (longint'(i) << (31 - TBL_BITS));
			acc = '0;
			if (y >= 64'h1_0000_0000)
				return 29'd1 << 28;
			for (int k = 27; k >= 0; k--) begin
				y = (y * y) >> 31;
				if (y >= 64'h1_0000_0000) begin
					y = y >> 1;
					acc[k] = 1'b1;
				end
			end
			return acc;
		endfunction

		// log10 of one float pattern; gives ST_OK, ST_NONPOS or ST_INVALID
		function logic [1:0] eval_log10(input logic [31:0] bits, output logic [31:0] value);
			int e;
			int idx;
			int rest;
			logic [23:0] m;
			logic [28:0] lo, hi, interp;
			longint v;
			longint unsigned mag, prod, res;
			value = '0;
			if (bits[30:23] == 8'hFF && bits[22:0] != '0)
				return ST_INVALID;
			if (bits[31] || bits[30:0] == '0)
				return ST_NONPOS;
			if (bits[30:23] == 8'hFF) begin
				value = 32'h7FFF_FFFF;
				return ST_OK;
			end
			m = {1'b0, bits[22:0]};
			if (bits[30:23] == 8'h00) begin
				// normalize the denormal until the hidden bit shows up
				e = -126;
				while (!m[23]) begin
					m = m << 1;
					e--;
				end
			end else begin
				e = int'(bits[30:23]) - 127;
			end
			idx  = int'(m[22:0] >> REST_BITS);
			rest = int'(m[22:0]) & ((1 << REST_BITS) - 1);
			lo = log2_tbl[idx];
			hi = log2_tbl[idx + 1];
			interp = lo;
			if (hi > lo)
				interp = lo + 29'((longint'(hi - lo) * longint'(rest)) >> REST_BITS);
			v = longint'(e) * (64'sd1 <<< 28) + longint'(interp);
			mag = (v < 0) ? longint'(-v) : longint'(v);
			prod = mag * LOG10_OF_2_Q30;
			// round half away from zero on the magnitude
			res = (prod >> SCALE_SHIFT) + ((prod >> (SCALE_SHIFT - 1)) & 64'd1);
			if (v < 0) begin
				if (res > 64'h8000_0000)
					res = 64'h8000_0000;
				value = 32'h0 - res[31:0];
			end else begin
				if (res > 64'h7FFF_FFFF)
					res = 64'h7FFF_FFFF;
				value = res[31:0];
			end
			return ST_OK;
		endfunction

		function void write_reg(logic index, logic [31:0] data);
			if (index == REG_USE_FLOOR)
				use_floor = data[0];
			else
				floor_bits = data;
		endfunction

		// note an accepted sample; produced tells whether a result follows
		function void note_sample(input logic [31:0] bits, input bit last, output bit produced);
			log_result_t r;
			logic [1:0] st;
			logic [31:0] val;
			produced = 1'b0;
			if (halted) begin
				// drop until the item marked last, which ends the drop silently
				if (last)
					halted = 1'b0;
				return;
			end
			st = eval_log10(bits, val);
			r.last = last;
			if (st == ST_NONPOS) begin
				if (use_floor) begin
					st = eval_log10(floor_bits, val);
					if (st == ST_OK) begin
						st = ST_FLOORED;
					end else begin
						st = ST_INVALID;
						val = '0;
					end
				end else begin
					val = '0;
					r.last = 1'b1;
					if (!last)
						halted = 1'b1;
				end
			end
			r.value  = val;
			r.status = st;
			expected_q.push_back(r);
			produced = 1'b1;
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		task report(string msg);
			errors++;
			if (errors <= 40)
				$display("ERROR at %0t: %s", $time, msg);
		endtask

		task check_result(logic [31:0] value, logic [1:0] status, logic last);
			log_result_t r;
			if (expected_q.size() == 0) begin
				report($sformatf("result %h/%0d/%0b with none expected", value, status, last));
				return;
			end
			r = expected_q.pop_front();
			if (value !== r.value)
				report($sformatf("log value %h, expected %h", value, r.value));
			if (status !== r.status)
				report($sformatf("status %0d, expected %0d", status, r.status));
			if (last !== r.last)
				report($sformatf("last flag %0b, expected %0b", last, r.last));
		endtask
	endclass

	// ------------------------------------------------------------------------
	// Block under test
	// ------------------------------------------------------------------------
	logic               clk;
	logic               arst_n;
	logic               cfg_we;
	logic               cfg_index;
	logic [31:0]        cfg_data;
	logic               s_tvalid;
	logic               s_tready;
	logic [31:0]        s_tdata;   // [31:0] sample_bits
	logic               s_tlast;
	logic               m_tvalid;
	logic               m_tready;
	logic signed [31:0] m_tdata;   // [31:0] log_value
	logic [1:0]         m_tuser;   // [1:0] status
	logic               m_tlast;

	floored_log10_stream dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

	log10_scoreboard sb;
	bit idling;   // when clear, both sides run without gaps or stalls

	initial clk = 1'b0;
	always #4 clk = ~clk;

	// Hard stop, far beyond the slowest correct run.
	initial begin
		#5ms;
		$display("** floored_log10_stream: FAILED **");
		$finish;
	end

	// ------------------------------------------------------------------------
	// Driver tasks; each starts and ends at a falling edge
	// ------------------------------------------------------------------------

	// Hold one sample on the input until its transfer, after a random gap.
	// Valid stays high into the next call so back-to-back items need no toggle.
	task automatic send_sample(input logic [31:0] bits, input bit last, output bit produced);
		int gap;
		gap = idling ? $urandom_range(0, 8) : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= bits;
		s_tlast  <= last;
		do @(posedge clk); while (!s_tready);
		sb.note_sample(bits, last, produced);
		@(negedge clk);
	endtask

	task automatic send(input logic [31:0] bits, input bit last);
		bit produced;
		send_sample(bits, last, produced);
	endtask

	// Drop valid, wait for every expected result, then let dropped items finish.
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (sb.pending() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic index, input logic [31:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= index;
		cfg_data  <= data;
		@(posedge clk);
		sb.write_reg(index, data);
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	// Draw a sample, weighted toward positive numbers with some of every kind.
	function automatic logic [31:0] pick_sample();
		int kind;
		logic [22:0] frac;
		kind = $urandom_range(0, 99);
		frac = 23'($urandom());
		if (kind < 50)
			return {1'b0, 8'($urandom_range(1, 254)), frac};
		if (kind < 60) begin
			// denormal, with a spread of leading zeros
			frac = frac >> $urandom_range(0, 22);
			return {9'h000, (frac == '0) ? 23'd1 : frac};
		end
		if (kind < 68)
			return $urandom();
		if (kind < 74)
			return {1'b0, 8'($urandom_range(126, 127)), frac};
		if (kind < 86) begin
			case ($urandom_range(0, 3))
				0: return 32'h0000_0000;
				1: return 32'h8000_0000;
				2: return 32'hFF80_0000;
				default: return {1'b1, 31'($urandom())};
			endcase
		end
		if (kind < 90)
			return 32'h7F80_0000;
		if (kind < 95)
			return {1'($urandom()), 8'hFF, (frac == '0) ? 23'h40_0000 : frac};
		return {1'b0, ($urandom_range(0, 1) != 0) ? 8'hFE : 8'h01, frac};
	endfunction

	// Arrays of random length ending in last, with a little broken framing.
	task automatic run_arrays(input int target);
		int done;
		int len;
		bit last;
		bit produced;
		done = 0;
		while (done < target) begin
			len = $urandom_range(1, 12);
			for (int j = 0; j < len; j++) begin
				last = (j == len - 1);
				if ($urandom_range(0, 99) < 3)
					last = ~last;
				send_sample(pick_sample(), last, produced);
				if (produced)
					done++;
			end
		end
	endtask

	// ------------------------------------------------------------------------
	// Result side: stall at random, then check each transfer
	// ------------------------------------------------------------------------
	initial begin : result_sink
		int stall;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			stall = idling ? $urandom_range(0, 8) : 0;
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			sb.check_result(m_tdata, m_tuser, m_tlast);
			@(negedge clk);
		end
	end

	// ------------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------------
	initial begin : stimulus
		logic [31:0] floor_set [PHASES];
		bit          floor_on  [PHASES];
		sb = new();
		arst_n    = 1'b0;
		cfg_we    = 1'b0;
		cfg_index = REG_USE_FLOOR;
		cfg_data  = '0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tlast   = 1'b0;
		m_tready  = 1'b0;
		idling    = 1'b1;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Reset settings: floor off. Cover exponent and mantissa extremes,
		// the specials, and error drop up to the item marked last.
		send(32'h0000_0001, 1'b0);   // smallest denormal
		send(32'h007F_FFFF, 1'b0);   // largest denormal
		send(32'h0080_0000, 1'b0);   // smallest normal
		send(32'h3F80_0000, 1'b0);   // exactly one
		send(32'h3FFF_FFFF, 1'b0);   // top of the table
		send(32'h4120_0000, 1'b0);
		send(32'h7F7F_FFFF, 1'b0);   // largest finite
		send(32'h7F80_0000, 1'b0);   // +inf saturates
		send(32'h7FC0_0000, 1'b0);   // NaN does not halt
		send(32'hFFFF_FFFF, 1'b1);
		send(32'h0000_0000, 1'b0);   // zero mid-array: error, then drop
		send(32'h3F80_0000, 1'b0);
		send(32'h7FC0_0000, 1'b0);
		send(32'h8000_0000, 1'b1);   // ends the drop, no result
		send(32'h8000_0000, 1'b1);   // negative zero on the last item
		send(32'hFF80_0000, 1'b0);   // -inf starts another drop
		send(32'h4000_0000, 1'b1);
		send(32'hC120_0000, 1'b1);
		send(32'h3E80_0000, 1'b1);
		wait_drained();

		// Floor on at its reset value, then a NaN floor.
		write_reg(REG_USE_FLOOR, 32'd1);
		send(32'h0000_0000, 1'b0);
		send(32'h8000_0000, 1'b0);
		send(32'hBF80_0000, 1'b0);
		send(32'hFF80_0000, 1'b1);
		wait_drained();
		write_reg(REG_FLOOR_BITS, 32'h7FC0_0000);
		send(32'h0000_0000, 1'b1);
		wait_drained();

		// Random phases, each under its own floor setting.
		floor_set = '{32'h0, 32'h3F80_0000, 32'h0000_0001, 32'h7F7F_FFFF,
			32'h7F80_0000, 32'h7FC0_0001, 32'h0000_0000, 32'h8000_0000,
			32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0};
		floor_on = '{1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1,
			1'b1, 1'b0, 1'b1, 1'b0};
		floor_set[0]  = $urandom();
		floor_set[8]  = {1'b0, 8'($urandom_range(1, 254)), 23'($urandom())};
		floor_set[11] = $urandom();
		for (int p = 0; p < PHASES; p++) begin
			write_reg(REG_USE_FLOOR, {31'd0, floor_on[p]});
			write_reg(REG_FLOOR_BITS, floor_set[p]);
			// one phase runs flat out on both sides
			idling = (p != 4);
			run_arrays(RESULTS_PER_PHASE);
			wait_drained();
		end

		if (sb.errors == 0)
			$display("** floored_log10_stream: PASSED **");
		else
			$display("** floored_log10_stream: FAILED **");
		$finish;
	end

endmodule
